### hdl/fmc_pkg.sv
// shared types and codes for the factor model covariance block
`timescale 1ns / 1ps
package fmc_pkg;

    typedef enum logic [1:0] {
        FN_LOAD_LAMBDA = 2'd0,
        FN_LOAD_PHI    = 2'd1,
        FN_LOAD_PSI    = 2'd2,
        FN_QUERY       = 2'd3
    } func_t;

    typedef enum logic {
        REG_NUM_ITEMS   = 1'b0,
        REG_NUM_FACTORS = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_DRAIN = 2'd2,
        ST_ROUND = 2'd3
    } st_t;

    typedef struct packed {
        func_t              func;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [15:0] value;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } head_t;

    localparam int ACC_W  = 56;
    localparam int FRAC_SHIFT = 20;
    localparam int PSI_SHIFT  = 24;

endpackage

### hdl/factor_model_covariance.sv
// top level of the factor model implied covariance block
`timescale 1ns / 1ps
// usage
//   requests enter on start with func, row, col and value and are taken
//   when start is high and busy is low. loads write one entry of the
//   loading, factor covariance or unique covariance store and give no
//   result; loads outside the store are dropped. a query returns one
//   element of lambda*phi*lambda' + psi on cov_value, saturated and
//   index_error, marked by done for exactly one cycle.
//   a two entry queue sits between the request side and the compute side,
//   so busy rises only when both entries hold requests.
//   a load is written into its store as the engine takes it from the queue.
//   a query passes through the run, drain and round states: in run the
//   single shared multiply-accumulate handles one triple product per cycle,
//   drain empties its pipeline, and round rounds and saturates the sum;
//   done is raised as the block returns to idle.
//   an out of range query is answered from idle without entering the run state.
//   num_items and num_factors are written through cfg_we, cfg_index and
//   cfg_data; the user must do so while the block is idle, as it does not check.
//   reset empties the queue, clears the accumulator and sets num_items to
//   16 and num_factors to 1; the stores hold nothing until written.
//   the receiver cannot stall; done is never held off.
module factor_model_covariance #(
    parameter int MAX_ITEMS   = 16,
    parameter int MAX_FACTORS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [3:0]         row,
    input  logic [3:0]         col,
    input  logic signed [15:0] value,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data,
    output logic               done,
    output logic signed [31:0] cov_value,
    output logic               saturated,
    output logic               index_error
);
    logic [4:0]     num_items_reg;
    logic [3:0]     num_factors_reg;
    fmc_pkg::req_t  in_req;
    fmc_pkg::head_t head;
    logic           pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_items_reg   <= 5'd16;
            num_factors_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (fmc_pkg::reg_idx_t'(cfg_index))
                fmc_pkg::REG_NUM_ITEMS:   num_items_reg   <= cfg_data;
                fmc_pkg::REG_NUM_FACTORS: num_factors_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign in_req.func  = fmc_pkg::func_t'(func);
    assign in_req.row   = row;
    assign in_req.col   = col;
    assign in_req.value = value;

    fmc_front #(.MAX_ITEMS(MAX_ITEMS), .MAX_FACTORS(MAX_FACTORS)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .in_req(in_req), .head(head), .pop(pop)
    );

    fmc_engine #(.MAX_ITEMS(MAX_ITEMS), .MAX_FACTORS(MAX_FACTORS)) u_engine (
        .clk(clk), .rst_n(rst_n), .head(head), .pop(pop),
        .num_items(num_items_reg), .num_factors(num_factors_reg),
        .done(done), .cov_value(cov_value), .saturated(saturated),
        .index_error(index_error)
    );
endmodule

### hdl/fmc_ram.sv
// generic ram, one write port, one registered read port
`timescale 1ns / 1ps
module fmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/fmc_front.sv
// front end: request accept, load range check, two entry request queue
`timescale 1ns / 1ps
module fmc_front #(
    parameter int MAX_ITEMS   = 16,
    parameter int MAX_FACTORS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  fmc_pkg::req_t  in_req,
    output fmc_pkg::head_t head,
    input  logic           pop
);
    fmc_pkg::req_t q_reg [0:1];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          accept, keep, push, do_pop;

    assign busy   = (count_reg == 2'd2);
    assign accept = start && !busy;

    // out of range loads are dropped here
    always_comb
    begin
        unique case (in_req.func)
            fmc_pkg::FN_LOAD_LAMBDA:
                keep = (int'(in_req.row) < MAX_ITEMS) && (int'(in_req.col) < MAX_FACTORS);
            fmc_pkg::FN_LOAD_PHI:
                keep = (int'(in_req.row) < MAX_FACTORS) && (int'(in_req.col) < MAX_FACTORS);
            fmc_pkg::FN_LOAD_PSI:
                keep = (int'(in_req.row) < MAX_ITEMS) && (int'(in_req.col) < MAX_ITEMS);
            default:
                keep = 1'b1;
        endcase
    end

    assign push   = accept && keep;
    assign do_pop = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.req   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

### hdl/fmc_engine.sv
// back end: matrix stores and shared multiply-accumulate for queries
`timescale 1ns / 1ps
module fmc_engine #(
    parameter int MAX_ITEMS   = 16,
    parameter int MAX_FACTORS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fmc_pkg::head_t     head,
    output logic               pop,
    input  logic [4:0]         num_items,
    input  logic [3:0]         num_factors,
    output logic               done,
    output logic signed [31:0] cov_value,
    output logic               saturated,
    output logic               index_error
);
    localparam int LD  = MAX_ITEMS * MAX_FACTORS;
    localparam int PD  = MAX_FACTORS * MAX_FACTORS;
    localparam int SD  = MAX_ITEMS * MAX_ITEMS;
    localparam int LAW = (LD > 1) ? $clog2(LD) : 1;
    localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
    localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
    localparam int NW  = $clog2(MAX_ITEMS + 1);
    localparam int FW  = $clog2(MAX_FACTORS + 1);
    localparam int RW  = fmc_pkg::ACC_W - fmc_pkg::FRAC_SHIFT;

    fmc_pkg::st_t state_reg, state_next;
    logic [3:0]   i_reg, i_next, j_reg, j_next;
    logic [FW-1:0] d_reg, d_next, e_reg, e_next;
    logic         first_reg, first_next;
    logic         v1_reg, v2_reg, v3_reg;
    logic signed [31:0] p1_reg;
    logic signed [15:0] lj_reg;
    logic signed [47:0] p2_reg;
    logic signed [fmc_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic         done_reg, done_next;
    logic signed [31:0] cov_reg, cov_next;
    logic         sat_reg, sat_next, err_reg, err_next;

    logic [NW-1:0] n_eff;
    logic [FW-1:0] f_eff;
    logic [3:0]    qi, qj;
    logic          q_err, issue, last_step, is_load;
    logic          we_lam, we_phi, we_psi;
    logic [LAW-1:0] lam_waddr, lam_a_raddr, lam_b_raddr;
    logic [PAW-1:0] phi_waddr, phi_raddr;
    logic [SAW-1:0] psi_waddr, psi_raddr;
    logic [15:0]    lam_a_rdata, lam_b_rdata, phi_rdata, psi_rdata;
    logic signed [fmc_pkg::ACC_W:0] rnd;
    logic signed [RW:0] shifted;

    always_comb
    begin
        priority if (num_items == 5'd0)
            n_eff = NW'(1);
        else if (int'(num_items) > MAX_ITEMS)
            n_eff = NW'(MAX_ITEMS);
        else
            n_eff = NW'(num_items);
        priority if (num_factors == 4'd0)
            f_eff = FW'(1);
        else if (int'(num_factors) > MAX_FACTORS)
            f_eff = FW'(MAX_FACTORS);
        else
            f_eff = FW'(num_factors);
    end

    assign qi    = (head.req.row < head.req.col) ? head.req.row : head.req.col;
    assign qj    = (head.req.row < head.req.col) ? head.req.col : head.req.row;
    assign q_err = (int'(head.req.row) >= int'(n_eff)) || (int'(head.req.col) >= int'(n_eff));

    assign pop     = (state_reg == fmc_pkg::ST_IDLE) && head.valid;
    assign is_load = head.req.func != fmc_pkg::FN_QUERY;
    assign we_lam  = pop && (head.req.func == fmc_pkg::FN_LOAD_LAMBDA);
    assign we_phi  = pop && (head.req.func == fmc_pkg::FN_LOAD_PHI);
    assign we_psi  = pop && (head.req.func == fmc_pkg::FN_LOAD_PSI);

    assign lam_waddr = LAW'(int'(head.req.row) * MAX_FACTORS + int'(head.req.col));
    assign phi_waddr = PAW'(int'(head.req.row) * MAX_FACTORS + int'(head.req.col));
    assign psi_waddr = SAW'(int'(head.req.row) * MAX_ITEMS + int'(head.req.col));
    assign psi_raddr = SAW'(int'(qi) * MAX_ITEMS + int'(qj));
    assign lam_a_raddr = LAW'(int'(i_reg) * MAX_FACTORS + int'(d_reg));
    assign lam_b_raddr = LAW'(int'(j_reg) * MAX_FACTORS + int'(e_reg));
    assign phi_raddr   = PAW'(int'(d_reg) * MAX_FACTORS + int'(e_reg));

    fmc_ram #(.WIDTH(16), .DEPTH(LD)) u_lam_a (
        .clk(clk), .we(we_lam), .waddr(lam_waddr), .wdata(head.req.value),
        .raddr(lam_a_raddr), .rdata(lam_a_rdata)
    );
    fmc_ram #(.WIDTH(16), .DEPTH(LD)) u_lam_b (
        .clk(clk), .we(we_lam), .waddr(lam_waddr), .wdata(head.req.value),
        .raddr(lam_b_raddr), .rdata(lam_b_rdata)
    );
    fmc_ram #(.WIDTH(16), .DEPTH(PD)) u_phi (
        .clk(clk), .we(we_phi), .waddr(phi_waddr), .wdata(head.req.value),
        .raddr(phi_raddr), .rdata(phi_rdata)
    );
    fmc_ram #(.WIDTH(16), .DEPTH(SD)) u_psi (
        .clk(clk), .we(we_psi), .waddr(psi_waddr), .wdata(head.req.value),
        .raddr(psi_raddr), .rdata(psi_rdata)
    );

    assign issue     = (state_reg == fmc_pkg::ST_RUN);
    assign last_step = (d_reg == f_eff - FW'(1)) && (e_reg == f_eff - FW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fmc_pkg::ST_IDLE:
                if (pop && !is_load && !q_err)
                    state_next = fmc_pkg::ST_RUN;
            fmc_pkg::ST_RUN:
                if (last_step)
                    state_next = fmc_pkg::ST_DRAIN;
            fmc_pkg::ST_DRAIN:
                if (!v1_reg && !v2_reg && !v3_reg)
                    state_next = fmc_pkg::ST_ROUND;
            fmc_pkg::ST_ROUND:
                state_next = fmc_pkg::ST_IDLE;
            default:
                state_next = fmc_pkg::ST_IDLE;
        endcase
    end

    // rounding to q16.16 with saturation
    assign rnd     = {acc_reg[fmc_pkg::ACC_W-1], acc_reg}
                     + (fmc_pkg::ACC_W+1)'(1 << (fmc_pkg::FRAC_SHIFT - 1));
    assign shifted = rnd[fmc_pkg::ACC_W:fmc_pkg::FRAC_SHIFT];

    // datapath and outputs
    always_comb
    begin
        i_next     = i_reg;
        j_next     = j_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        first_next = 1'b0;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        cov_next   = cov_reg;
        sat_next   = sat_reg;
        err_next   = err_reg;
        if (first_reg)
            acc_next = fmc_pkg::ACC_W'($signed(psi_rdata)) <<< fmc_pkg::PSI_SHIFT;
        else if (v3_reg)
            acc_next = acc_reg + fmc_pkg::ACC_W'(p2_reg);
        unique case (state_reg)
            fmc_pkg::ST_IDLE:
                if (pop && !is_load)
                begin
                    i_next = qi;
                    j_next = qj;
                    d_next = '0;
                    e_next = '0;
                    if (q_err)
                    begin
                        done_next = 1'b1;
                        cov_next  = '0;
                        sat_next  = 1'b0;
                        err_next  = 1'b1;
                    end
                    else
                        first_next = 1'b1;
                end
            fmc_pkg::ST_RUN:
                if (e_reg == f_eff - FW'(1))
                begin
                    e_next = '0;
                    d_next = d_reg + FW'(1);
                end
                else
                    e_next = e_reg + FW'(1);
            fmc_pkg::ST_DRAIN:
                ;
            fmc_pkg::ST_ROUND:
            begin
                done_next = 1'b1;
                err_next  = 1'b0;
                priority if (shifted > (RW+1)'(32'sh7FFFFFFF))
                begin
                    cov_next = 32'sh7FFFFFFF;
                    sat_next = 1'b1;
                end
                else if (shifted < -(RW+1)'(64'sh80000000))
                begin
                    cov_next = 32'sh80000000;
                    sat_next = 1'b1;
                end
                else
                begin
                    cov_next = shifted[31:0];
                    sat_next = 1'b0;
                end
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= $signed(lam_a_rdata) * $signed(phi_rdata);
        lj_reg <= $signed(lam_b_rdata);
        p2_reg <= p1_reg * lj_reg;
        i_reg  <= i_next;
        j_reg  <= j_next;
        d_reg  <= d_next;
        e_reg  <= e_next;
        cov_reg <= cov_next;
        sat_reg <= sat_next;
        err_reg <= err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmc_pkg::ST_IDLE;
            first_reg <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            acc_reg   <= acc_next;
            done_reg  <= done_next;
        end
    end

    assign done        = done_reg;
    assign cov_value   = cov_reg;
    assign saturated   = sat_reg;
    assign index_error = err_reg;
endmodule

### verif/tb_factor_model_covariance.sv
// testbench for the factor model implied covariance block
`timescale 1ns / 1ps
module tb_factor_model_covariance;

    localparam int N_ITEMS   = 16;
    localparam int N_FACTORS = 8;
    localparam int SETTLE    = 80;

    typedef struct {
        logic signed [31:0] cov;
        logic               sat;
        logic               err;
    } cov_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    fmc_pkg::func_t     func;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
    logic               cfg_we;
    fmc_pkg::reg_idx_t  cfg_index;
    logic [4:0]         cfg_data;
    logic               done;
    logic signed [31:0] cov_value;
    logic               saturated;
    logic               index_error;

    logic signed [15:0] lam_store [N_ITEMS][N_FACTORS];
    logic signed [15:0] phi_store [N_FACTORS][N_FACTORS];
    logic signed [15:0] psi_store [N_ITEMS][N_ITEMS];
    logic [4:0]         items_reg;
    logic [3:0]         factors_reg;

    cov_result_t pending_cov[$];
    int fail_count = 0;
    int query_count = 0;
    int load_count = 0;
    int err_count = 0;
    int sat_count = 0;
    int idle_pct = 0;

    factor_model_covariance uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .row(row), .col(col), .value(value),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .cov_value(cov_value), .saturated(saturated),
        .index_error(index_error)
    );

    always #4 clk = ~clk;

    function automatic cov_result_t predict_element(int r, int c);
        cov_result_t res;
        int n;
        int f;
        int i;
        int j;
        longint acc;
        longint rounded;
        n = (items_reg < 1) ? 1 : (items_reg > N_ITEMS) ? N_ITEMS : items_reg;
        f = (factors_reg < 1) ? 1 : (factors_reg > N_FACTORS) ? N_FACTORS : factors_reg;
        res.cov = '0;
        res.sat = 1'b0;
        res.err = 1'b0;
        if (r >= n || c >= n)
        begin
            res.err = 1'b1;
            return res;
        end
        i = (r < c) ? r : c;
        j = (r < c) ? c : r;
        acc = longint'(psi_store[i][j]) * (64'sd1 <<< fmc_pkg::PSI_SHIFT);
        for (int d = 0; d < f; d++)
            for (int e = 0; e < f; e++)
                acc += longint'(lam_store[i][d]) * longint'(phi_store[d][e])
                       * longint'(lam_store[j][e]);
        rounded = (acc + (64'sd1 <<< (fmc_pkg::FRAC_SHIFT - 1))) >>> fmc_pkg::FRAC_SHIFT;
        if (rounded > 64'sd2147483647)
        begin
            rounded = 64'sd2147483647;
            res.sat = 1'b1;
        end
        else if (rounded < -64'sd2147483648)
        begin
            rounded = -64'sd2147483648;
            res.sat = 1'b1;
        end
        res.cov = rounded[31:0];
        return res;
    endfunction

    // one request; start stays high when the next one follows directly
    task automatic send_request(fmc_pkg::func_t f, int r, int c, int v);
        cov_result_t res;
        start <= 1'b1;
        func  <= f;
        row   <= r[3:0];
        col   <= c[3:0];
        value <= v[15:0];
        do
            @(posedge clk);
        while (busy);
        case (f)
            fmc_pkg::FN_LOAD_LAMBDA: if (c < N_FACTORS) lam_store[r][c] = v[15:0];
            fmc_pkg::FN_LOAD_PHI:
                if (r < N_FACTORS && c < N_FACTORS) phi_store[r][c] = v[15:0];
            fmc_pkg::FN_LOAD_PSI:    psi_store[r][c] = v[15:0];
            default:
            begin
                res = predict_element(r, c);
                pending_cov.push_back(res);
                query_count++;
                if (res.err) err_count++;
                if (res.sat) sat_count++;
            end
        endcase
        if (f != fmc_pkg::FN_QUERY) load_count++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_cov.size() != 0);
    endtask

    task automatic write_reg(fmc_pkg::reg_idx_t idx, int data);
        wait_results();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[4:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == fmc_pkg::REG_NUM_ITEMS) items_reg = data[4:0];
        else factors_reg = data[3:0];
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_cov.size() == 0)
            begin
                $error("result with no request waiting");
                fail_count++;
            end
            else
            begin
                cov_result_t exp_res;
                exp_res = pending_cov.pop_front();
                if (cov_value !== exp_res.cov)
                begin
                    $error("cov_value expected %0d got %0d", exp_res.cov, cov_value);
                    fail_count++;
                end
                if (saturated !== exp_res.sat)
                begin
                    $error("saturated expected %0d got %0d", exp_res.sat, saturated);
                    fail_count++;
                end
                if (index_error !== exp_res.err)
                begin
                    $error("index_error expected %0d got %0d", exp_res.err, index_error);
                    fail_count++;
                end
            end
        end
    end

    function automatic fmc_pkg::func_t random_func();
        int k;
        k = $urandom_range(99);
        if (k < 45) return fmc_pkg::FN_QUERY;
        if (k < 65) return fmc_pkg::FN_LOAD_LAMBDA;
        if (k < 80) return fmc_pkg::FN_LOAD_PHI;
        return fmc_pkg::FN_LOAD_PSI;
    endfunction

    task automatic test_fill();
        for (int r = 0; r < N_ITEMS; r++)
            for (int c = 0; c < N_FACTORS; c++)
                send_request(fmc_pkg::FN_LOAD_LAMBDA, r, c, $urandom_range(65535));
        for (int r = 0; r < N_FACTORS; r++)
            for (int c = 0; c < N_FACTORS; c++)
                send_request(fmc_pkg::FN_LOAD_PHI, r, c, $urandom_range(65535));
        for (int r = 0; r < N_ITEMS; r++)
            for (int c = 0; c < N_ITEMS; c++)
                send_request(fmc_pkg::FN_LOAD_PSI, r, c, $urandom_range(65535));
    endtask

    task automatic test_directed();
        write_reg(fmc_pkg::REG_NUM_FACTORS, 2);
        send_request(fmc_pkg::FN_LOAD_LAMBDA, 0, 0, -32768);
        send_request(fmc_pkg::FN_LOAD_LAMBDA, 15, 1, 32767);
        send_request(fmc_pkg::FN_LOAD_LAMBDA, 3, 8, 1234);
        send_request(fmc_pkg::FN_LOAD_LAMBDA, 2, 15, -1);
        send_request(fmc_pkg::FN_LOAD_PHI, 1, 1, 32767);
        send_request(fmc_pkg::FN_LOAD_PHI, 8, 0, 77);
        send_request(fmc_pkg::FN_LOAD_PHI, 15, 15, 77);
        send_request(fmc_pkg::FN_LOAD_PSI, 0, 15, -32768);
        send_request(fmc_pkg::FN_LOAD_PSI, 15, 0, 32767);
        send_request(fmc_pkg::FN_QUERY, 0, 0, 0);
        send_request(fmc_pkg::FN_QUERY, 15, 15, 0);
        send_request(fmc_pkg::FN_QUERY, 0, 15, 0);
        send_request(fmc_pkg::FN_QUERY, 15, 0, 0);
        send_request(fmc_pkg::FN_QUERY, 7, 3, -1);
        wait_results();
        write_reg(fmc_pkg::REG_NUM_ITEMS, 4);
        send_request(fmc_pkg::FN_QUERY, 3, 3, 0);
        send_request(fmc_pkg::FN_QUERY, 4, 0, 0);
        send_request(fmc_pkg::FN_QUERY, 0, 15, 0);
        send_request(fmc_pkg::FN_QUERY, 15, 15, 0);
    endtask

    task automatic test_saturation();
        write_reg(fmc_pkg::REG_NUM_ITEMS, 16);
        write_reg(fmc_pkg::REG_NUM_FACTORS, 8);
        for (int r = 0; r < N_FACTORS; r++)
            for (int c = 0; c < N_FACTORS; c++)
                send_request(fmc_pkg::FN_LOAD_PHI, r, c, 32767);
        for (int c = 0; c < N_FACTORS; c++)
        begin
            send_request(fmc_pkg::FN_LOAD_LAMBDA, 0, c, -32768);
            send_request(fmc_pkg::FN_LOAD_LAMBDA, 1, c, 32767);
        end
        send_request(fmc_pkg::FN_LOAD_PSI, 0, 0, 32767);
        send_request(fmc_pkg::FN_LOAD_PSI, 0, 1, -32768);
        send_request(fmc_pkg::FN_QUERY, 0, 0, 0);
        send_request(fmc_pkg::FN_QUERY, 0, 1, 0);
        send_request(fmc_pkg::FN_QUERY, 1, 0, 0);
        send_request(fmc_pkg::FN_QUERY, 1, 1, 0);
    endtask

    task automatic test_registers();
        int item_vals[6]   = '{0, 1, 5, 16, 17, 31};
        int factor_vals[6] = '{0, 1, 3, 8, 9, 15};
        for (int k = 0; k < 6; k++)
        begin
            write_reg(fmc_pkg::REG_NUM_ITEMS, item_vals[k]);
            write_reg(fmc_pkg::REG_NUM_FACTORS, factor_vals[5 - k]);
            repeat (12)
                send_request(fmc_pkg::FN_QUERY, $urandom_range(15), $urandom_range(15),
                             $urandom_range(65535));
        end
    endtask

    task automatic test_random(int pct, int count);
        idle_pct = pct;
        write_reg(fmc_pkg::REG_NUM_ITEMS, $urandom_range(31));
        write_reg(fmc_pkg::REG_NUM_FACTORS, $urandom_range(15));
        for (int k = 0; k < count; k++)
        begin
            send_request(random_func(), $urandom_range(15), $urandom_range(15),
                         $urandom_range(65535));
            if (k == count / 2) wait_results();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        func      <= fmc_pkg::FN_LOAD_LAMBDA;
        row       <= '0;
        col       <= '0;
        value     <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= fmc_pkg::REG_NUM_ITEMS;
        cfg_data  <= '0;
        items_reg   = 5'd16;
        factors_reg = 4'd1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill();
        test_directed();
        test_saturation();
        test_registers();
        test_random(23, 275);
        test_random(59, 275);
        test_random(0, 275);

        wait_results();
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d loads and %0d queries", load_count, query_count);
        $display("%0d out of range queries, %0d saturated results", err_count, sat_count);
        if (fail_count == 0 && pending_cov.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(8 * 1_500_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
